// ===== rtl/urc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// urc_pkg
// Shared types, register codes and reset values for the ultrasonic ranger.
// ----------------------------------------------------------------------------
package urc_pkg;

  localparam int unsigned CountWidthDefault = 18;
  localparam int unsigned TicksWidth        = 18;
  localparam int unsigned TimeoutWidth      = 18;
  localparam int unsigned ByteWidth         = 8;
  localparam int unsigned DistWidth         = 26;
  localparam int unsigned CfgIndexWidth     = 3;
  localparam int unsigned CfgDataWidth      = 18;
  localparam int unsigned InDataWidth       = 8;
  localparam int unsigned OutFieldsWidth    = 5 + TicksWidth + DistWidth;
  localparam int unsigned OutDataWidth      = ((OutFieldsWidth + 7) / 8) * 8;

  localparam logic [TimeoutWidth-1:0] ReadyTimeoutReset = 18'd25000;
  localparam logic [ByteWidth-1:0]    TrigWidthReset    = 8'd20;
  localparam logic [TimeoutWidth-1:0] RiseTimeoutReset  = 18'd5000;
  localparam logic [TimeoutWidth-1:0] FallTimeoutReset  = 18'd230000;
  localparam logic [ByteWidth-1:0]    HalfSpeedReset    = 8'd170;

  typedef enum logic [CfgIndexWidth-1:0] {
    CFG_READY_TIMEOUT = 3'd0,
    CFG_TRIG_WIDTH    = 3'd1,
    CFG_RISE_TIMEOUT  = 3'd2,
    CFG_FALL_TIMEOUT  = 3'd3,
    CFG_HALF_SPEED    = 3'd4
  } cfg_idx_e;

  typedef enum logic [4:0] {
    PH_IDLE  = 5'b00001,
    PH_READY = 5'b00010,
    PH_TRIG  = 5'b00100,
    PH_RISE  = 5'b01000,
    PH_FALL  = 5'b10000
  } phase_e;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_STUCK   = 2'd1,
    ST_NO_RISE = 2'd2,
    ST_NO_FALL = 2'd3
  } status_e;

  // per-tick result before the distance multiply
  typedef struct packed {
    logic                  trigger;
    logic                  busy;
    logic                  done;
    status_e               status;
    logic [TicksWidth-1:0] ticks;
  } tick_res_t;

endpackage

// ===== rtl/ultrasonic_ranger_controller.sv =====
`timescale 1ns / 1ps
// Pipeline: an accepted tick passes through the tick register, then the output register
// holding the distance product, before its result leaves.
// Throughput: one tick per cycle; the sequencer step and the 18x8 multiply each fit in
// one stage, stalls only when the output is not taken.
// Reset: rst_ni clears phase, counter, echo history, valid flags and sets the
// configuration registers to their default values.
// ----------------------------------------------------------------------------
// ultrasonic_ranger_controller
// Trigger/echo sequencer with timeouts and echo-to-distance scaling.
// ----------------------------------------------------------------------------
module ultrasonic_ranger_controller #(
  parameter int unsigned COUNT_WIDTH = urc_pkg::CountWidthDefault
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // config write channel
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [urc_pkg::CfgIndexWidth-1:0]   cfg_index_i,
  input  logic [urc_pkg::CfgDataWidth-1:0]    cfg_data_i,
  // tick stream
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // [0] start_req, [1] echo_level, [7:2] zero
  input  logic [urc_pkg::InDataWidth-1:0]     s_axis_tdata,
  // result stream
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // [0] trigger, [1] busy_res, [2] done_res, [4:3] status, [22:5] echo_ticks,
  // [48:23] distance_um, [55:49] zero
  output logic [urc_pkg::OutDataWidth-1:0]    m_axis_tdata
);

  localparam int unsigned TW   = urc_pkg::TicksWidth;
  localparam int unsigned CmpW = (COUNT_WIDTH > TW) ? COUNT_WIDTH : TW;
  localparam logic [CmpW-1:0] TicksMax = CmpW'({TW{1'b1}});

  // configuration registers
  logic [urc_pkg::TimeoutWidth-1:0] ready_to_q, rise_to_q, fall_to_q;
  logic [urc_pkg::ByteWidth-1:0]    trig_w_q, half_speed_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ready_to_q   <= urc_pkg::ReadyTimeoutReset;
      trig_w_q     <= urc_pkg::TrigWidthReset;
      rise_to_q    <= urc_pkg::RiseTimeoutReset;
      fall_to_q    <= urc_pkg::FallTimeoutReset;
      half_speed_q <= urc_pkg::HalfSpeedReset;
    end else if (cfg_valid_i) begin
      unique case (urc_pkg::cfg_idx_e'(cfg_index_i))
        urc_pkg::CFG_READY_TIMEOUT: ready_to_q <= cfg_data_i;
        urc_pkg::CFG_TRIG_WIDTH:    trig_w_q   <= cfg_data_i[urc_pkg::ByteWidth-1:0];
        urc_pkg::CFG_RISE_TIMEOUT:  rise_to_q  <= cfg_data_i;
        urc_pkg::CFG_FALL_TIMEOUT:  fall_to_q  <= cfg_data_i;
        urc_pkg::CFG_HALF_SPEED:    half_speed_q <= cfg_data_i[urc_pkg::ByteWidth-1:0];
        default: ;
      endcase
    end
  end

  // pipeline handshake
  logic a_valid_q, b_valid_q;
  logic a_adv, in_xfer;

  assign a_adv         = !b_valid_q || m_axis_tready;
  assign s_axis_tready = !a_valid_q || a_adv;
  assign in_xfer       = s_axis_tvalid && s_axis_tready;

  // sequencer state
  urc_pkg::phase_e          phase_q, phase_d;
  logic [COUNT_WIDTH-1:0]   cnt_q, cnt_d;
  logic                     prev_echo_q;
  urc_pkg::tick_res_t       res_d, res_q;

  logic                     start, echo;
  logic [COUNT_WIDTH-1:0]   nc;
  logic [CmpW-1:0]          nc_ext, cnt_ext;
  logic                     nc_sat;
  logic                     fire_ready, fire_trig, fire_rise, fire_fall;

  assign start   = s_axis_tdata[0];
  assign echo    = s_axis_tdata[1];
  assign nc      = (&cnt_q) ? cnt_q : cnt_q + 1'b1;
  assign nc_sat  = &nc;
  assign nc_ext  = CmpW'(nc);
  assign cnt_ext = CmpW'(cnt_q);

  assign fire_ready = (nc_ext >= CmpW'(ready_to_q)) || nc_sat;
  assign fire_trig  = (nc_ext >= CmpW'(trig_w_q))   || nc_sat;
  assign fire_rise  = (nc_ext >= CmpW'(rise_to_q))  || nc_sat;
  assign fire_fall  = (nc_ext >= CmpW'(fall_to_q))  || nc_sat;

  always_comb begin
    phase_d = phase_q;
    cnt_d   = cnt_q;
    res_d   = '0;
    res_d.status = urc_pkg::ST_OK;
    unique case (phase_q)
      urc_pkg::PH_READY: begin
        res_d.busy = 1'b1;
        if (!echo) begin
          phase_d = urc_pkg::PH_TRIG;
          cnt_d   = '0;
        end else if (fire_ready) begin
          res_d.done   = 1'b1;
          res_d.status = urc_pkg::ST_STUCK;
          phase_d      = urc_pkg::PH_IDLE;
          cnt_d        = '0;
        end else begin
          cnt_d = nc;
        end
      end
      urc_pkg::PH_TRIG: begin
        res_d.busy    = 1'b1;
        res_d.trigger = 1'b1;
        if (fire_trig) begin
          phase_d = urc_pkg::PH_RISE;
          cnt_d   = '0;
        end else begin
          cnt_d = nc;
        end
      end
      urc_pkg::PH_RISE: begin
        res_d.busy = 1'b1;
        if (echo) begin
          phase_d = urc_pkg::PH_FALL;
          cnt_d   = COUNT_WIDTH'(1);
        end else if (fire_rise) begin
          res_d.done   = 1'b1;
          res_d.status = urc_pkg::ST_NO_RISE;
          phase_d      = urc_pkg::PH_IDLE;
          cnt_d        = '0;
        end else begin
          cnt_d = nc;
        end
      end
      urc_pkg::PH_FALL: begin
        res_d.busy = 1'b1;
        if (!echo && prev_echo_q) begin
          res_d.done  = 1'b1;
          res_d.ticks = (cnt_ext > TicksMax) ? TicksMax[TW-1:0] : cnt_ext[TW-1:0];
          phase_d     = urc_pkg::PH_IDLE;
          cnt_d       = '0;
        end else if (fire_fall) begin
          res_d.done   = 1'b1;
          res_d.status = urc_pkg::ST_NO_FALL;
          phase_d      = urc_pkg::PH_IDLE;
          cnt_d        = '0;
        end else begin
          cnt_d = nc;
        end
      end
      default: begin
        // idle, and any corrupted code recovers here
        phase_d = urc_pkg::PH_IDLE;
        if (start) begin
          phase_d = urc_pkg::PH_READY;
          cnt_d   = '0;
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= urc_pkg::PH_IDLE;
      cnt_q       <= '0;
      prev_echo_q <= 1'b0;
      a_valid_q   <= 1'b0;
    end else if (in_xfer) begin
      phase_q     <= phase_d;
      cnt_q       <= cnt_d;
      prev_echo_q <= echo;
      a_valid_q   <= 1'b1;
    end else if (a_adv) begin
      a_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      res_q <= res_d;
    end
  end

  // distance scaling and output register
  logic [TW+urc_pkg::ByteWidth-1:0]     prod;
  logic [urc_pkg::OutDataWidth-1:0]     out_d, out_q;

  assign prod  = res_q.ticks * half_speed_q;
  assign out_d = urc_pkg::OutDataWidth'({prod[urc_pkg::DistWidth-1:0], res_q.ticks,
                                         res_q.status, res_q.done, res_q.busy,
                                         res_q.trigger});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_valid_q <= 1'b0;
    end else if (a_adv) begin
      b_valid_q <= a_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (a_adv && a_valid_q) begin
      out_q <= out_d;
    end
  end

  assign m_axis_tvalid = b_valid_q;
  assign m_axis_tdata  = out_q;

endmodule

// ===== rtl/urc_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// urc_checker
// Port-level checks on the ranger result stream.
// ----------------------------------------------------------------------------
module urc_checker (
  input logic                             clk_i,
  input logic                             rst_ni,
  input logic                             m_axis_tvalid,
  input logic                             m_axis_tready,
  input logic [urc_pkg::OutDataWidth-1:0] m_axis_tdata
);

  logic       trig, busy, done;
  logic [1:0] status;
  logic [17:0] ticks;
  logic [25:0] dist_um;

  assign trig    = m_axis_tdata[0];
  assign busy    = m_axis_tdata[1];
  assign done    = m_axis_tdata[2];
  assign status  = m_axis_tdata[4:3];
  assign ticks   = m_axis_tdata[22:5];
  assign dist_um = m_axis_tdata[48:23];

  // stalled transfer holds
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");

  a_trig_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && trig |-> busy && !done)
    else $error("trigger outside the trigger phase");

  a_fields_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !done |-> status == 2'd0 && ticks == '0 && dist_um == '0)
    else $error("measurement fields set without done");

  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && done && status != 2'd0 |-> ticks == '0 && dist_um == '0 && busy)
    else $error("failed measurement reports a distance");

endmodule

bind ultrasonic_ranger_controller urc_checker u_urc_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

// ===== sim/urc_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// urc_tb_checker
// Watches the config, tick and result channels of the ultrasonic ranger,
// predicts one result per accepted tick and compares it with what leaves.
// ----------------------------------------------------------------------------
module urc_tb_checker #(
  parameter int unsigned COUNT_WIDTH = urc_pkg::CountWidthDefault
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_valid_i,
  input  logic                              cfg_ready_i,
  input  logic [urc_pkg::CfgIndexWidth-1:0] cfg_index_i,
  input  logic [urc_pkg::CfgDataWidth-1:0]  cfg_data_i,
  input  logic                              tick_valid_i,
  input  logic                              tick_ready_i,
  input  logic [urc_pkg::InDataWidth-1:0]   tick_data_i,
  input  logic                              res_valid_i,
  input  logic                              res_ready_i,
  input  logic [urc_pkg::OutDataWidth-1:0]  res_data_i,
  output int                                mismatches_o,
  output int                                pending_o
);

  localparam logic [31:0] CountMax = (32'd1 << COUNT_WIDTH) - 32'd1;
  localparam logic [31:0] TicksMax = (32'd1 << urc_pkg::TicksWidth) - 32'd1;

  typedef struct packed {
    logic                           trigger;
    logic                           busy;
    logic                           done;
    urc_pkg::status_e               status;
    logic [urc_pkg::TicksWidth-1:0] ticks;
    logic [urc_pkg::DistWidth-1:0]  dist_um;
  } ranger_res_t;

  logic [urc_pkg::TimeoutWidth-1:0] ready_to;
  logic [urc_pkg::ByteWidth-1:0]    trig_w;
  logic [urc_pkg::TimeoutWidth-1:0] rise_to;
  logic [urc_pkg::TimeoutWidth-1:0] fall_to;
  logic [urc_pkg::ByteWidth-1:0]    half_speed;

  urc_pkg::phase_e ph;
  logic [31:0]     tick_cnt;
  logic            last_echo;

  ranger_res_t expected_results[$];

  // One microsecond tick of the sequencer; updates the shadow state.
  task automatic advance_sequencer(input logic start, input logic echo,
                                   output ranger_res_t r);
    logic [31:0] nxt;
    logic [31:0] len;
    logic [31:0] prod;
    r   = '0;
    nxt = (tick_cnt >= CountMax) ? CountMax : tick_cnt + 32'd1;
    case (ph)
      urc_pkg::PH_READY: begin
        r.busy = 1'b1;
        if (!echo) begin
          ph       = urc_pkg::PH_TRIG;
          tick_cnt = '0;
        end else if (nxt >= ready_to || nxt == CountMax) begin
          r.done   = 1'b1;
          r.status = urc_pkg::ST_STUCK;
          ph       = urc_pkg::PH_IDLE;
          tick_cnt = '0;
        end else begin
          tick_cnt = nxt;
        end
      end
      urc_pkg::PH_TRIG: begin
        r.busy    = 1'b1;
        r.trigger = 1'b1;
        if (nxt >= trig_w || nxt == CountMax) begin
          ph       = urc_pkg::PH_RISE;
          tick_cnt = '0;
        end else begin
          tick_cnt = nxt;
        end
      end
      urc_pkg::PH_RISE: begin
        r.busy = 1'b1;
        if (echo) begin
          ph       = urc_pkg::PH_FALL;
          tick_cnt = 32'd1;
        end else if (nxt >= rise_to || nxt == CountMax) begin
          r.done   = 1'b1;
          r.status = urc_pkg::ST_NO_RISE;
          ph       = urc_pkg::PH_IDLE;
          tick_cnt = '0;
        end else begin
          tick_cnt = nxt;
        end
      end
      urc_pkg::PH_FALL: begin
        r.busy = 1'b1;
        if (!echo && last_echo) begin
          len       = (tick_cnt > TicksMax) ? TicksMax : tick_cnt;
          prod      = len * {24'd0, half_speed};
          r.done    = 1'b1;
          r.status  = urc_pkg::ST_OK;
          r.ticks   = len[urc_pkg::TicksWidth-1:0];
          r.dist_um = prod[urc_pkg::DistWidth-1:0];
          ph        = urc_pkg::PH_IDLE;
          tick_cnt  = '0;
        end else if (nxt >= fall_to || nxt == CountMax) begin
          r.done   = 1'b1;
          r.status = urc_pkg::ST_NO_FALL;
          ph       = urc_pkg::PH_IDLE;
          tick_cnt = '0;
        end else begin
          tick_cnt = nxt;
        end
      end
      default: begin
        ph = urc_pkg::PH_IDLE;
        if (start) begin
          ph       = urc_pkg::PH_READY;
          tick_cnt = '0;
        end
      end
    endcase
    last_echo = echo;
  endtask

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      $error("%s mismatch: expected %0d, actual %0d", name, want, got);
      mismatches_o++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : monitor
    ranger_res_t want;
    ranger_res_t got;
    if (!rst_ni) begin
      ready_to     = urc_pkg::ReadyTimeoutReset;
      trig_w       = urc_pkg::TrigWidthReset;
      rise_to      = urc_pkg::RiseTimeoutReset;
      fall_to      = urc_pkg::FallTimeoutReset;
      half_speed   = urc_pkg::HalfSpeedReset;
      ph           = urc_pkg::PH_IDLE;
      tick_cnt     = '0;
      last_echo    = 1'b0;
      mismatches_o = 0;
      expected_results.delete();
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          urc_pkg::CFG_READY_TIMEOUT: ready_to   = cfg_data_i[urc_pkg::TimeoutWidth-1:0];
          urc_pkg::CFG_TRIG_WIDTH:    trig_w     = cfg_data_i[urc_pkg::ByteWidth-1:0];
          urc_pkg::CFG_RISE_TIMEOUT:  rise_to    = cfg_data_i[urc_pkg::TimeoutWidth-1:0];
          urc_pkg::CFG_FALL_TIMEOUT:  fall_to    = cfg_data_i[urc_pkg::TimeoutWidth-1:0];
          urc_pkg::CFG_HALF_SPEED:    half_speed = cfg_data_i[urc_pkg::ByteWidth-1:0];
          default: ;
        endcase
      end
      // check leaving results first: a result never belongs to a tick of the same edge
      if (res_valid_i && res_ready_i) begin
        if (expected_results.size() == 0) begin
          $error("result transfer with no tick outstanding");
          mismatches_o++;
        end else begin
          want        = expected_results.pop_front();
          got.trigger = res_data_i[0];
          got.busy    = res_data_i[1];
          got.done    = res_data_i[2];
          got.status  = urc_pkg::status_e'(res_data_i[4:3]);
          got.ticks   = res_data_i[22:5];
          got.dist_um = res_data_i[48:23];
          check_field("trigger", 32'(want.trigger), 32'(got.trigger));
          check_field("busy_res", 32'(want.busy), 32'(got.busy));
          check_field("done_res", 32'(want.done), 32'(got.done));
          check_field("status", 32'(want.status), 32'(got.status));
          check_field("echo_ticks", 32'(want.ticks), 32'(got.ticks));
          check_field("distance_um", 32'(want.dist_um), 32'(got.dist_um));
        end
      end
      if (tick_valid_i && tick_ready_i) begin
        advance_sequencer(tick_data_i[0], tick_data_i[1], want);
        expected_results.push_back(want);
      end
    end
    pending_o = expected_results.size();
  end

endmodule

// ===== sim/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Drives microsecond ticks shaped as measurement sequences into the ranger,
// reprograms timeouts and scale between phases, and stalls the result side.
// ----------------------------------------------------------------------------
module tb;

  logic                              clk_i;
  logic                              rst_ni;
  logic                              cfg_valid;
  logic                              cfg_ready;
  logic [urc_pkg::CfgIndexWidth-1:0] cfg_index;
  logic [urc_pkg::CfgDataWidth-1:0]  cfg_data;
  logic                              s_tvalid;
  logic                              s_tready;
  logic [urc_pkg::InDataWidth-1:0]   s_tdata;
  logic                              m_tvalid;
  logic                              m_tready;
  logic [urc_pkg::OutDataWidth-1:0]  m_tdata;

  int mismatches;
  int pending;
  int sent_cnt;
  bit tx_idle;
  bit rx_idle;
  bit hold_rx;

  // stimulus-side copy of the programmed values, used only to size sequences
  int cur_ready;
  int cur_trig;
  int cur_rise;
  int cur_fall;

  ultrasonic_ranger_controller dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid),
    .cfg_ready_o   (cfg_ready),
    .cfg_index_i   (cfg_index),
    .cfg_data_i    (cfg_data),
    .s_axis_tvalid (s_tvalid),
    .s_axis_tready (s_tready),
    .s_axis_tdata  (s_tdata),
    .m_axis_tvalid (m_tvalid),
    .m_axis_tready (m_tready),
    .m_axis_tdata  (m_tdata)
  );

  urc_tb_checker u_tb_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid),
    .cfg_ready_i  (cfg_ready),
    .cfg_index_i  (cfg_index),
    .cfg_data_i   (cfg_data),
    .tick_valid_i (s_tvalid),
    .tick_ready_i (s_tready),
    .tick_data_i  (s_tdata),
    .res_valid_i  (m_tvalid),
    .res_ready_i  (m_tready),
    .res_data_i   (m_tdata),
    .mismatches_o (mismatches),
    .pending_o    (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  initial begin
    #40_000_000;
    $display("ultrasonic_ranger_controller test failed");
    $finish;
  end

  function automatic logic sometimes();
    return ($urandom_range(0, 3) == 0);
  endfunction

  function automatic logic coin();
    return 1'($urandom);
  endfunction

  // Length of a level run: mostly inside the limit; at or past it now and then for limits up to 64.
  function automatic int pick_len(input int lim);
    int cap;
    cap = (lim < 1) ? 1 : lim;
    if (cap > 64) begin
      return ($urandom_range(0, 19) == 0) ? int'($urandom_range(200, 1500))
                                          : int'($urandom_range(0, 40));
    end
    return ($urandom_range(0, 3) == 0) ? cap + int'($urandom_range(0, 2))
                                       : int'($urandom_range(0, cap - 1));
  endfunction

  // Called at a falling edge; returns at the falling edge after the transfer.
  task automatic send_tick(input logic start, input logic echo);
    int gap;
    gap = tx_idle ? int'($urandom_range(0, 17)) : 0;
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {6'd0, echo, start};
    do @(posedge clk_i); while (!s_tready);
    @(negedge clk_i);
    sent_cnt++;
  endtask

  // Hold the tick stream until every result is back, then let the pipe settle.
  task automatic drain();
    s_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic write_reg(input urc_pkg::cfg_idx_e idx,
                           input logic [urc_pkg::CfgDataWidth-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk_i); while (!cfg_ready);
    @(negedge clk_i);
  endtask

  task automatic program_regs(input logic [17:0] rdy, input logic [7:0] trig,
                              input logic [17:0] rise, input logic [17:0] fall,
                              input logic [7:0] speed);
    logic [9:0] junk_a;
    logic [9:0] junk_b;
    junk_a = 10'($urandom);
    junk_b = 10'($urandom);
    // upper bits of the byte-wide registers carry junk that must be dropped
    write_reg(urc_pkg::CFG_READY_TIMEOUT, rdy);
    write_reg(urc_pkg::CFG_TRIG_WIDTH, {junk_a, trig});
    write_reg(urc_pkg::CFG_RISE_TIMEOUT, rise);
    write_reg(urc_pkg::CFG_FALL_TIMEOUT, fall);
    write_reg(urc_pkg::CFG_HALF_SPEED, {junk_b, speed});
    cfg_valid <= 1'b0;
    cur_ready = int'(rdy);
    cur_trig  = int'(trig);
    cur_rise  = int'(rise);
    cur_fall  = int'(fall);
  endtask

  // One measurement: start, echo busy, trigger, wait for rise, echo pulse.
  task automatic measure_seq();
    int n;
    n = $urandom_range(0, 3);
    repeat (n) send_tick(1'b0, coin());
    send_tick(1'b1, coin());
    n = pick_len(cur_ready);
    repeat (n) send_tick(sometimes(), 1'b1);
    send_tick(sometimes(), 1'b0);
    n = (cur_trig < 1) ? 1 : cur_trig;
    repeat (n) send_tick(sometimes(), coin());
    n = pick_len(cur_rise);
    repeat (n) send_tick(sometimes(), 1'b0);
    send_tick(sometimes(), 1'b1);
    n = pick_len(cur_fall);
    repeat (n) send_tick(sometimes(), 1'b1);
    send_tick(sometimes(), 1'b0);
  endtask

  task automatic run_phase(input logic [17:0] rdy, input logic [7:0] trig,
                           input logic [17:0] rise, input logic [17:0] fall,
                           input logic [7:0] speed, input int n_items,
                           input bit idle_on);
    int target;
    drain();
    program_regs(rdy, trig, rise, fall, speed);
    tx_idle = idle_on && ($urandom_range(0, 3) != 0);
    rx_idle = idle_on && ($urandom_range(0, 3) != 0);
    target  = sent_cnt + n_items;
    while (sent_cnt < target) begin
      if ($urandom_range(0, 9) == 0) begin
        repeat ($urandom_range(1, 8)) send_tick(coin(), coin());
      end else begin
        measure_seq();
      end
    end
  endtask

  task automatic run_random_phase(input int n_items, input bit idle_on);
    run_phase(18'($urandom_range(1, 12)), 8'($urandom_range(1, 8)),
              18'($urandom_range(1, 16)), 18'($urandom_range(1, 40)),
              8'($urandom_range(1, 255)), n_items, idle_on);
  endtask

  // result side: random back-pressure, with one long hold on request
  initial begin : result_sink
    int gap;
    m_tready = 1'b0;
    @(posedge rst_ni);
    @(negedge clk_i);
    forever begin
      gap = rx_idle ? int'($urandom_range(0, 17)) : 0;
      if (hold_rx) begin
        gap     = 400;
        hold_rx = 1'b0;
      end
      if (gap > 0) begin
        m_tready <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      m_tready <= 1'b1;
      do @(posedge clk_i); while (!m_tvalid);
      @(negedge clk_i);
    end
  end

  initial begin : stimulus
    rst_ni    = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = urc_pkg::CFG_READY_TIMEOUT;
    cfg_data  = '0;
    s_tvalid  = 1'b0;
    s_tdata   = '0;
    sent_cnt  = 0;
    tx_idle   = 1'b0;
    rx_idle   = 1'b0;
    hold_rx   = 1'b0;
    cur_ready = int'(urc_pkg::ReadyTimeoutReset);
    cur_trig  = int'(urc_pkg::TrigWidthReset);
    cur_rise  = int'(urc_pkg::RiseTimeoutReset);
    cur_fall  = int'(urc_pkg::FallTimeoutReset);
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // reset settings: a clean measurement with a start request while busy
    send_tick(1'b0, 1'b1);
    send_tick(1'b1, 1'b1);
    send_tick(1'b1, 1'b1);
    send_tick(1'b0, 1'b0);
    for (int i = 0; i < 20; i++) send_tick(1'(i), 1'(i >> 1));
    send_tick(1'b0, 1'b0);
    send_tick(1'b0, 1'b0);
    send_tick(1'b0, 1'b1);
    send_tick(1'b1, 1'b1);
    send_tick(1'b0, 1'b1);
    send_tick(1'b0, 1'b0);

    // smallest limits, zero limits (act as one), largest limits
    run_phase(18'd1, 8'd1, 18'd1, 18'd1, 8'd1, 150, 1'b1);
    run_phase(18'd0, 8'd0, 18'd0, 18'd0, 8'd0, 150, 1'b1);
    run_phase(18'h3FFFF, 8'hFF, 18'h3FFFF, 18'h3FFFF, 8'hFF, 300, 1'b1);

    run_random_phase(220, 1'b0);
    // long result hold while ticks keep coming, so the pipe fills and stalls
    drain();
    hold_rx = 1'b1;
    repeat (40) send_tick(coin(), coin());
    run_random_phase(180, 1'b1);
    repeat (4) run_random_phase(220, 1'b1);

    drain();
    repeat (8) @(negedge clk_i);
    if (mismatches == 0 && pending == 0) begin
      $display("ultrasonic_ranger_controller test passed");
    end else begin
      $display("ultrasonic_ranger_controller test failed");
    end
    $finish;
  end

endmodule
